/* rtl/fsdd_pkg.sv */
package fsdd_pkg;

  // Frame header bytes
  localparam logic [7:0] HDR_ONE = 8'hFD;
  localparam logic [7:0] HDR_TWO = 8'hFE;

  // Item command codes
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam int unsigned PULSE_W = 21;
  localparam int unsigned VALUE_W = 16;

  // Drive configuration
  typedef struct packed {
    logic [11:0] center_value;
    logic [11:0] dead_band;
    logic [12:0] reverse_span;
    logic [4:0]  forward_gain;
    logic [4:0]  reverse_gain;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    center_value: 12'd2000,
    dead_band:    12'd100,
    reverse_span: 13'd4000,
    forward_gain: 5'd16,
    reverse_gain: 5'd14
  };

  localparam logic signed [VALUE_W-1:0] SETPOINT_RESET = 16'sd2000;

endpackage

/* rtl/framed_setpoint_deadband_drive_top.sv */
// Framed setpoint receiver with deadband drive.
// Input channel (in_valid_i/in_ready_o) carries one word per item: cmd_i = 0
// with a received byte in rx_byte_i, or cmd_i = 1 for a drive timer tick.
// Byte words run the frame parser (0xFD opens channel 1, 0xFE channel 2, then
// low byte, high byte). Tick words compare channel 1 with center +/- deadband
// and produce a forward or reverse pulse count.
// Output channel (out_valid_o/out_ready_i) returns exactly one result word per
// input word, in order.
// A word passes the input register, then the result register (out_valid_o).
// Throughput: one word per cycle unless the receiver stalls, set by the
// single-pass compute between the two registers; both stages advance together.
// When the receiver stalls, the result register holds and the input register
// still takes one more word; in_ready_o drops only when both are full.
// Reset clears both stages, sets parser to idle, both setpoints to 2000 and
// the configuration registers to their defaults. The APB port is always
// ready; write configuration only while no words are in flight.
module framed_setpoint_deadband_drive_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Configuration
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic        [4:0]                    paddr,
  input  logic        [31:0]                   pwdata,
  output logic        [31:0]                   prdata,
  output logic                                 pready,
  // Input words
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 cmd_i,
  input  logic        [7:0]                    rx_byte_i,
  // Result words
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic        [fsdd_pkg::PULSE_W-1:0]  forward_pulse_o,
  output logic        [fsdd_pkg::PULSE_W-1:0]  reverse_pulse_o,
  output logic signed [fsdd_pkg::VALUE_W-1:0]  channel_one_value_o,
  output logic signed [fsdd_pkg::VALUE_W-1:0]  channel_two_value_o,
  output logic                                 channel_one_updated_o,
  output logic                                 channel_two_updated_o
);
  import fsdd_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_ONE_LO = 3'd1,
    PH_ONE_HI = 3'd2,
    PH_TWO_LO = 3'd3,
    PH_TWO_HI = 3'd4
  } phase_e;

  localparam logic [2:0] REG_CENTER = 3'd0;
  localparam logic [2:0] REG_DEAD   = 3'd1;
  localparam logic [2:0] REG_SPAN   = 3'd2;
  localparam logic [2:0] REG_FGAIN  = 3'd3;
  localparam logic [2:0] REG_RGAIN  = 3'd4;

  // Configuration registers
  cfg_t        cfg_q;
  logic [2:0]  reg_idx;
  logic        cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_CENTER: cfg_q.center_value <= pwdata[11:0];
        REG_DEAD:   cfg_q.dead_band    <= pwdata[11:0];
        REG_SPAN:   cfg_q.reverse_span <= pwdata[12:0];
        REG_FGAIN:  cfg_q.forward_gain <= pwdata[4:0];
        REG_RGAIN:  cfg_q.reverse_gain <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (reg_idx)
      REG_CENTER: prdata = {20'd0, cfg_q.center_value};
      REG_DEAD:   prdata = {20'd0, cfg_q.dead_band};
      REG_SPAN:   prdata = {19'd0, cfg_q.reverse_span};
      REG_FGAIN:  prdata = {27'd0, cfg_q.forward_gain};
      REG_RGAIN:  prdata = {27'd0, cfg_q.reverse_gain};
      default:    prdata = '0;
    endcase
  end

  // Stage handshake
  logic       s1_valid_q;
  logic       s1_cmd_q;
  logic [7:0] s1_byte_q;
  logic       out_valid_q;
  logic       advance;

  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_cmd_q   <= CMD_BYTE;
      s1_byte_q  <= '0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
      s1_cmd_q   <= cmd_i;
      s1_byte_q  <= rx_byte_i;
    end
  end

  // Parser state
  phase_e                     phase_q, phase_d;
  logic [7:0]                 low_one_q, low_one_d;
  logic [7:0]                 low_two_q, low_two_d;
  logic signed [VALUE_W-1:0]  sp_one_q, sp_one_d;
  logic signed [VALUE_W-1:0]  sp_two_q, sp_two_d;
  logic                       upd_one_d, upd_two_d;
  logic                       is_tick, is_hdr;

  logic [PULSE_W-1:0]         fwd_d, rev_d;
  logic signed [VALUE_W-1:0]  sp_drive;

  assign is_tick = (s1_cmd_q == CMD_TICK);
  assign is_hdr  = (s1_byte_q == HDR_ONE) || (s1_byte_q == HDR_TWO);

  fsdd_drive u_drive (
    .tick_i          (is_tick),
    .cfg_i           (cfg_q),
    .setpoint_i      (sp_one_q),
    .forward_pulse_o (fwd_d),
    .reverse_pulse_o (rev_d),
    .setpoint_o      (sp_drive)
  );

  // Next state for one word
  always_comb begin
    phase_d   = phase_q;
    low_one_d = low_one_q;
    low_two_d = low_two_q;
    sp_one_d  = sp_one_q;
    sp_two_d  = sp_two_q;
    upd_one_d = 1'b0;
    upd_two_d = 1'b0;
    if (is_tick) begin
      sp_one_d = sp_drive;
    end else begin
      unique case (phase_q)
        PH_ONE_LO: begin
          if (is_hdr) begin
            phase_d = PH_IDLE;
          end else begin
            low_one_d = s1_byte_q;
            phase_d   = PH_ONE_HI;
          end
        end
        PH_ONE_HI: begin
          phase_d = PH_IDLE;
          if (!is_hdr) begin
            sp_one_d  = {s1_byte_q, low_one_q};
            upd_one_d = 1'b1;
          end
        end
        PH_TWO_LO: begin
          if (is_hdr) begin
            phase_d = PH_IDLE;
          end else begin
            low_two_d = s1_byte_q;
            phase_d   = PH_TWO_HI;
          end
        end
        PH_TWO_HI: begin
          phase_d = PH_IDLE;
          if (!is_hdr) begin
            sp_two_d  = {s1_byte_q, low_two_q};
            upd_two_d = 1'b1;
          end
        end
        default: begin
          if (s1_byte_q == HDR_ONE) begin
            phase_d = PH_ONE_LO;
          end else if (s1_byte_q == HDR_TWO) begin
            phase_d = PH_TWO_LO;
          end else begin
            phase_d = PH_IDLE;
          end
        end
      endcase
    end
  end

  // State and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q               <= PH_IDLE;
      low_one_q             <= '0;
      low_two_q             <= '0;
      sp_one_q              <= SETPOINT_RESET;
      sp_two_q              <= SETPOINT_RESET;
      out_valid_q           <= 1'b0;
      forward_pulse_o       <= '0;
      reverse_pulse_o       <= '0;
      channel_one_value_o   <= '0;
      channel_two_value_o   <= '0;
      channel_one_updated_o <= 1'b0;
      channel_two_updated_o <= 1'b0;
    end else begin
      if (advance) begin
        phase_q               <= phase_d;
        low_one_q             <= low_one_d;
        low_two_q             <= low_two_d;
        sp_one_q              <= sp_one_d;
        sp_two_q              <= sp_two_d;
        out_valid_q           <= 1'b1;
        forward_pulse_o       <= fwd_d;
        reverse_pulse_o       <= rev_d;
        channel_one_value_o   <= sp_one_d;
        channel_two_value_o   <= sp_two_d;
        channel_one_updated_o <= upd_one_d;
        channel_two_updated_o <= upd_two_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

/* rtl/fsdd_drive.sv */
module fsdd_drive (
  input  logic                                 tick_i,
  input  fsdd_pkg::cfg_t                       cfg_i,
  input  logic signed [fsdd_pkg::VALUE_W-1:0]  setpoint_i,
  output logic        [fsdd_pkg::PULSE_W-1:0]  forward_pulse_o,
  output logic        [fsdd_pkg::PULSE_W-1:0]  reverse_pulse_o,
  output logic signed [fsdd_pkg::VALUE_W-1:0]  setpoint_o
);
  import fsdd_pkg::*;

  // 18-bit signed working width covers span - value - center
  logic signed [17:0] v_s;
  logic signed [17:0] v_eff;
  logic signed [17:0] c_s;
  logic signed [17:0] hi_thr;
  logic signed [17:0] lo_thr;
  logic signed [17:0] fwd_diff;
  logic signed [17:0] rev_term;
  logic               zero_fix;

  always_comb begin
    v_s      = {{2{setpoint_i[VALUE_W-1]}}, setpoint_i};
    c_s      = {6'd0, cfg_i.center_value};
    hi_thr   = c_s + {6'd0, cfg_i.dead_band};
    lo_thr   = c_s - {6'd0, cfg_i.dead_band};
    zero_fix = tick_i && (setpoint_i == '0);
    v_eff    = zero_fix ? c_s : v_s;
    fwd_diff = v_s - c_s;
    rev_term = {5'd0, cfg_i.reverse_span} - v_eff - c_s;

    // Forward: above the upper deadband edge
    forward_pulse_o = '0;
    if (tick_i && (v_s > hi_thr)) begin
      forward_pulse_o = {5'd0, fwd_diff[15:0]} * {16'd0, cfg_i.forward_gain};
    end

    // Reverse: below the lower edge, only for a positive term
    reverse_pulse_o = '0;
    if (tick_i && (v_eff < lo_thr) && (rev_term > 18'sd0)) begin
      reverse_pulse_o = {5'd0, rev_term[15:0]} * {16'd0, cfg_i.reverse_gain};
    end

    // On a tick, a zero setpoint is replaced by center
    setpoint_o = zero_fix ? VALUE_W'(signed'({4'd0, cfg_i.center_value})) : setpoint_i;
  end

endmodule
